FILE: rtl/core/tsw_pkg.sv
// tsw_pkg: shared types, constants and helper functions of the texture sampler
// no dependencies; imported by every other file of the block
`default_nettype none

package tsw_pkg;

    // fixed field widths
    localparam int COORD_W    = 18;
    localparam int SIZE_W     = 7;
    localparam int MODE_W     = 2;
    localparam int POS_W      = 6;
    localparam int TEXEL_W    = 32;
    localparam int CHAN_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // default sizing
    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;
    localparam int DEF_FRAC_BITS  = 16;

    localparam logic [SIZE_W-1:0] RST_TEX_WIDTH  = 7'd64;
    localparam logic [SIZE_W-1:0] RST_TEX_HEIGHT = 7'd64;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    typedef enum logic [MODE_W-1:0] {
        FILT_NEAREST  = 2'd0,
        FILT_DITHER   = 2'd1,
        FILT_BILINEAR = 2'd2
    } filt_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEX_WIDTH   = 2'd0,
        CFG_TEX_HEIGHT  = 2'd1,
        CFG_FILTER_MODE = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [SIZE_W-1:0] tex_width;
        logic [SIZE_W-1:0] tex_height;
        logic [MODE_W-1:0] filter_mode;
    } cfg_t;

    // command to the shared multiply-accumulate unit
    typedef struct packed {
        logic issue;
        logic clear;
    } mac_ctl_t;

    // multiplier operand widths as a function of the fraction width
    function automatic int mac_a_w(input int frac_bits);
        return (COORD_W > CHAN_W + frac_bits) ? COORD_W : CHAN_W + frac_bits;
    endfunction

    function automatic int mac_b_w(input int frac_bits);
        return frac_bits + 1;
    endfunction

    function automatic int mac_acc_w(input int frac_bits);
        return mac_a_w(frac_bits) + mac_b_w(frac_bits) + 1;
    endfunction

    // dither offsets in quarter texels, {du, dv}
    function automatic logic [3:0] dither_quarters(input logic sy, input logic sx);
        logic [3:0] q;
        case ({sy, sx})
            2'b00:   q = {2'd1, 2'd0};
            2'b01:   q = {2'd2, 2'd3};
            2'b10:   q = {2'd3, 2'd2};
            default: q = {2'd0, 2'd1};
        endcase
        return q;
    endfunction

    // channel c of a texel, red first
    function automatic logic [CHAN_W-1:0] texel_chan(input logic [TEXEL_W-1:0] t,
                                                     input logic [1:0] c);
        logic [CHAN_W-1:0] v;
        case (c)
            2'd0:    v = t[31:24];
            2'd1:    v = t[23:16];
            2'd2:    v = t[15:8];
            default: v = t[7:0];
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tsw_if.sv
// tsw_if: request, result and register-write channels of the texture sampler
// depends on tsw_pkg for field widths
`default_nettype none

interface tsw_req_if import tsw_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                op;
    logic [POS_W-1:0]    write_x;
    logic [POS_W-1:0]    write_y;
    logic [TEXEL_W-1:0]  write_value;
    logic [COORD_W-1:0]  coord_u;
    logic [COORD_W-1:0]  coord_v;
    logic                screen_x_odd;
    logic                screen_y_odd;

    modport source (
        output valid, op, write_x, write_y, write_value, coord_u, coord_v,
               screen_x_odd, screen_y_odd,
        input  ready
    );
    modport sink (
        input  valid, op, write_x, write_y, write_value, coord_u, coord_v,
               screen_x_odd, screen_y_odd,
        output ready
    );
endinterface

interface tsw_rsp_if import tsw_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic [CHAN_W-1:0]  alpha;

    modport source (output valid, red, green, blue, alpha, input ready);
    modport sink (input valid, red, green, blue, alpha, output ready);
endinterface

interface tsw_cfg_if import tsw_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/tsw_mac.sv
// tsw_mac: shared multiply-accumulate unit, product registered before the add
// depends on tsw_pkg for the operand width functions and mac_ctl_t
`default_nettype none

module tsw_mac import tsw_pkg::*; #(
    parameter int  FRAC_BITS = DEF_FRAC_BITS,
    localparam int A_W       = mac_a_w(FRAC_BITS),
    localparam int B_W       = mac_b_w(FRAC_BITS),
    localparam int ACC_W     = mac_acc_w(FRAC_BITS)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  mac_ctl_t          ctl,
    input  logic [A_W-1:0]    a,
    input  logic [B_W-1:0]    b,
    output logic [ACC_W-1:0]  acc
);

    logic [A_W+B_W-1:0] prod_reg;
    logic               pend_reg;
    logic               clr_reg;
    logic [ACC_W-1:0]   acc_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
        if (pend_reg)
        begin
            acc_reg <= (clr_reg ? '0 : acc_reg) + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            clr_reg  <= 1'b0;
        end
        else
        begin
            pend_reg <= ctl.issue;
            clr_reg  <= ctl.clear;
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

FILE: rtl/core/tsw_texmem.sv
// tsw_texmem: texel memory, one write port and one read port with registered data
// depends on tsw_pkg for the texel width
`default_nettype none

module tsw_texmem import tsw_pkg::*; #(
    parameter int  DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                clk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  logic [TEXEL_W-1:0]  wdata,
    input  logic                re,
    input  logic [AW-1:0]       raddr,
    output logic [TEXEL_W-1:0]  rdata
);

    logic [TEXEL_W-1:0] mem [DEPTH];
    logic [TEXEL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/core/tsw_ctrl.sv
// tsw_ctrl: sequencer of the texture sampler, drives the shared mac and the texel memory
// depends on tsw_pkg, tsw_if, tsw_mac and tsw_texmem
`default_nettype none

module tsw_ctrl import tsw_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    tsw_req_if.sink    req,
    tsw_rsp_if.source  rsp
);

    localparam int A_W    = mac_a_w(FRAC_BITS);
    localparam int B_W    = mac_b_w(FRAC_BITS);
    localparam int ACC_W  = mac_acc_w(FRAC_BITS);
    localparam int IW     = COORD_W + SIZE_W - FRAC_BITS + 1;
    localparam int XW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_T1 = (IW > SIZE_W) ? IW : SIZE_W;
    localparam int CMP_T2 = ((XW > YW) ? XW : YW) + 1;
    localparam int CMP_W  = (CMP_T1 > CMP_T2) ? CMP_T1 : CMP_T2;
    localparam int R_W    = CHAN_W + FRAC_BITS;

    localparam logic [B_W-1:0]   ONE_FX     = B_W'(1) << FRAC_BITS;
    localparam logic [B_W-1:0]   QUARTER_FX = B_W'(1) << (FRAC_BITS - 2);
    localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (2 * FRAC_BITS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_MOD,
        ST_FETCH,
        ST_BLEND,
        ST_DONE
    } state_t;

    state_t                state_reg;
    logic [1:0]            step_reg;
    logic                  axis_reg;
    logic [2:0]            k_reg;
    logic [1:0]            chan_reg;
    logic [1:0]            phase_reg;
    logic                  out_valid_reg;

    logic [MODE_W-1:0]     mode_reg;
    logic [SIZE_W-1:0]     w_reg;
    logic [SIZE_W-1:0]     h_reg;
    logic [COORD_W-1:0]    cu_reg;
    logic [COORD_W-1:0]    cv_reg;
    logic [1:0]            du_reg;
    logic [1:0]            dv_reg;
    logic [IW-1:0]         x0_reg;
    logic [IW-1:0]         y0_reg;
    logic [FRAC_BITS-1:0]  fu_reg;
    logic [FRAC_BITS-1:0]  fv_reg;
    logic                  incx_reg;
    logic                  incy_reg;
    logic [XW-1:0]         x_lo_reg;
    logic [XW-1:0]         x_hi_reg;
    logic [YW-1:0]         y_lo_reg;
    logic [YW-1:0]         y_hi_reg;
    logic [TEXEL_W-1:0]    tex_reg [4];
    logic [R_W-1:0]        r0_reg;
    logic [R_W-1:0]        r1_reg;
    logic [CHAN_W-1:0]     res_reg [4];
    logic [CHAN_W-1:0]     out_reg [4];

    mac_ctl_t              mac_ctl;
    logic [A_W-1:0]        mac_a;
    logic [B_W-1:0]        mac_b;
    logic [ACC_W-1:0]      mac_acc;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic [TEXEL_W-1:0]    mem_rdata;

    logic                  in_accept;
    logic                  is_bilinear;
    logic [3:0]            dq;
    logic                  x_ge;
    logic                  y_ge;
    logic [CMP_W-1:0]      x_sum;
    logic [CMP_W-1:0]      y_sum;
    logic [XW-1:0]         x_hi_next;
    logic [YW-1:0]         y_hi_next;
    logic [XW-1:0]         rd_x;
    logic [YW-1:0]         rd_y;
    logic [ACC_W-1:0]      acc_rnd;
    logic [CHAN_W:0]       chan_rnd;
    logic [CHAN_W-1:0]     chan_val;
    logic [2:0]            fetch_last;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                   input int max_v);
        if (v == '0)
            return SIZE_W'(1);
        else if (32'(v) > max_v)
            return SIZE_W'(max_v);
        else
            return v;
    endfunction

    tsw_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .a     (mac_a),
        .b     (mac_b),
        .acc   (mac_acc)
    );

    tsw_texmem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (req.write_value),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign req.ready   = (state_reg == ST_IDLE);
    assign in_accept   = req.valid && req.ready;
    assign is_bilinear = (mode_reg == FILT_BILINEAR);
    assign dq          = dither_quarters(req.screen_y_odd, req.screen_x_odd);

    // texel writes go straight to memory on acceptance
    assign mem_we    = in_accept && (req.op == OP_WRITE)
                       && (32'(req.write_x) < MAX_WIDTH)
                       && (32'(req.write_y) < MAX_HEIGHT);
    assign mem_waddr = AW'(req.write_y) * AW'(MAX_WIDTH) + AW'(req.write_x);

    // wrap reduction and neighbor index
    assign x_ge      = CMP_W'(x0_reg) >= CMP_W'(w_reg);
    assign y_ge      = CMP_W'(y0_reg) >= CMP_W'(h_reg);
    assign x_sum     = CMP_W'(x0_reg) + CMP_W'(incx_reg);
    assign y_sum     = CMP_W'(y0_reg) + CMP_W'(incy_reg);
    assign x_hi_next = (x_sum == CMP_W'(w_reg)) ? '0 : XW'(x_sum);
    assign y_hi_next = (y_sum == CMP_W'(h_reg)) ? '0 : YW'(y_sum);

    // fetch order: (lo,lo) (hi,lo) (lo,hi) (hi,hi)
    assign rd_x       = k_reg[0] ? x_hi_reg : x_lo_reg;
    assign rd_y       = k_reg[1] ? y_hi_reg : y_lo_reg;
    assign mem_raddr  = AW'(rd_y) * AW'(MAX_WIDTH) + AW'(rd_x);
    assign fetch_last = is_bilinear ? 3'd4 : 3'd1;
    assign mem_re     = (state_reg == ST_FETCH) && (k_reg < fetch_last);

    // round half up to 8 bits
    assign acc_rnd  = mac_acc + ROUND_HALF;
    assign chan_rnd = acc_rnd[2*FRAC_BITS +: CHAN_W+1];
    assign chan_val = chan_rnd[CHAN_W] ? '1 : chan_rnd[CHAN_W-1:0];

    // mac operands: step 0 clears and issues, step 1 issues, step 3 reads the sum
    always_comb
    begin
        mac_ctl       = '0;
        mac_a         = '0;
        mac_b         = '0;
        mac_ctl.issue = ((state_reg == ST_SCALE) || (state_reg == ST_BLEND))
                        && (step_reg == 2'd0 || step_reg == 2'd1);
        mac_ctl.clear = mac_ctl.issue && (step_reg == 2'd0);
        if (state_reg == ST_SCALE)
        begin
            if (step_reg == 2'd0)
            begin
                mac_a = axis_reg ? A_W'(cv_reg) : A_W'(cu_reg);
                mac_b = axis_reg ? B_W'(h_reg) : B_W'(w_reg);
            end
            else
            begin
                // dither offset plus half texel, nothing for bilinear
                mac_a = is_bilinear ? '0
                      : (axis_reg ? A_W'(dv_reg) : A_W'(du_reg)) + A_W'(2);
                mac_b = QUARTER_FX;
            end
        end
        else if (state_reg == ST_BLEND)
        begin
            case (phase_reg)
                2'd0:
                begin
                    mac_a = (step_reg == 2'd0) ? A_W'(texel_chan(tex_reg[0], chan_reg))
                                               : A_W'(texel_chan(tex_reg[1], chan_reg));
                    mac_b = (step_reg == 2'd0) ? ONE_FX - B_W'(fu_reg) : B_W'(fu_reg);
                end
                2'd1:
                begin
                    mac_a = (step_reg == 2'd0) ? A_W'(texel_chan(tex_reg[2], chan_reg))
                                               : A_W'(texel_chan(tex_reg[3], chan_reg));
                    mac_b = (step_reg == 2'd0) ? ONE_FX - B_W'(fu_reg) : B_W'(fu_reg);
                end
                default:
                begin
                    mac_a = (step_reg == 2'd0) ? A_W'(r0_reg) : A_W'(r1_reg);
                    mac_b = (step_reg == 2'd0) ? ONE_FX - B_W'(fv_reg) : B_W'(fv_reg);
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= 2'd0;
            axis_reg      <= 1'b0;
            k_reg         <= 3'd0;
            chan_reg      <= 2'd0;
            phase_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // a new result loads the output register, else a taken one leaves it
            if (state_reg == ST_DONE && (!out_valid_reg || rsp.ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.valid && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept && req.op == OP_SAMPLE)
                    begin
                        cu_reg   <= req.coord_u;
                        cv_reg   <= req.coord_v;
                        w_reg    <= eff_size(cfg.tex_width, MAX_WIDTH);
                        h_reg    <= eff_size(cfg.tex_height, MAX_HEIGHT);
                        mode_reg <= cfg.filter_mode;
                        du_reg   <= (cfg.filter_mode == FILT_DITHER) ? dq[3:2] : 2'd0;
                        dv_reg   <= (cfg.filter_mode == FILT_DITHER) ? dq[1:0] : 2'd0;
                        axis_reg <= 1'b0;
                        step_reg <= 2'd0;
                        if (cfg.filter_mode == FILT_NEAREST || cfg.filter_mode == FILT_DITHER
                            || cfg.filter_mode == FILT_BILINEAR)
                        begin
                            state_reg <= ST_SCALE;
                        end
                        else
                        begin
                            for (int i = 0; i < 4; i++)
                            begin
                                res_reg[i] <= '0;
                            end
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_SCALE:
                begin
                    step_reg <= step_reg + 2'd1;
                    if (step_reg == 2'd3)
                    begin
                        if (!axis_reg)
                        begin
                            x0_reg   <= mac_acc[FRAC_BITS +: IW];
                            fu_reg   <= mac_acc[FRAC_BITS-1:0];
                            incx_reg <= is_bilinear && (mac_acc[FRAC_BITS-1:0] != '0);
                            axis_reg <= 1'b1;
                        end
                        else
                        begin
                            y0_reg    <= mac_acc[FRAC_BITS +: IW];
                            fv_reg    <= mac_acc[FRAC_BITS-1:0];
                            incy_reg  <= is_bilinear && (mac_acc[FRAC_BITS-1:0] != '0);
                            state_reg <= ST_MOD;
                        end
                    end
                end
                ST_MOD:
                begin
                    if (x_ge)
                    begin
                        x0_reg <= x0_reg - IW'(w_reg);
                    end
                    if (y_ge)
                    begin
                        y0_reg <= y0_reg - IW'(h_reg);
                    end
                    if (!x_ge && !y_ge)
                    begin
                        x_lo_reg  <= XW'(x0_reg);
                        y_lo_reg  <= YW'(y0_reg);
                        x_hi_reg  <= x_hi_next;
                        y_hi_reg  <= y_hi_next;
                        k_reg     <= 3'd0;
                        state_reg <= ST_FETCH;
                    end
                end
                ST_FETCH:
                begin
                    k_reg <= k_reg + 3'd1;
                    if (k_reg != 3'd0)
                    begin
                        tex_reg[2'(k_reg - 3'd1)] <= mem_rdata;
                    end
                    if (k_reg == fetch_last)
                    begin
                        if (is_bilinear)
                        begin
                            chan_reg  <= 2'd0;
                            phase_reg <= 2'd0;
                            step_reg  <= 2'd0;
                            state_reg <= ST_BLEND;
                        end
                        else
                        begin
                            for (int i = 0; i < 4; i++)
                            begin
                                res_reg[i] <= texel_chan(mem_rdata, 2'(i));
                            end
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_BLEND:
                begin
                    step_reg <= step_reg + 2'd1;
                    if (step_reg == 2'd3)
                    begin
                        case (phase_reg)
                            2'd0:
                            begin
                                r0_reg    <= mac_acc[R_W-1:0];
                                phase_reg <= 2'd1;
                            end
                            2'd1:
                            begin
                                r1_reg    <= mac_acc[R_W-1:0];
                                phase_reg <= 2'd2;
                            end
                            default:
                            begin
                                res_reg[chan_reg] <= chan_val;
                                phase_reg         <= 2'd0;
                                chan_reg          <= chan_reg + 2'd1;
                                if (chan_reg == 2'd3)
                                begin
                                    state_reg <= ST_DONE;
                                end
                            end
                        endcase
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        for (int i = 0; i < 4; i++)
                        begin
                            out_reg[i] <= res_reg[i];
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.red   = out_reg[0];
    assign rsp.green = out_reg[1];
    assign rsp.blue  = out_reg[2];
    assign rsp.alpha = out_reg[3];

endmodule

`default_nettype wire

FILE: rtl/core/texture_sampler_wrap_bilinear.sv
// texture_sampler_wrap_bilinear: top level, register file and sequencer instance
// depends on tsw_pkg, tsw_if and tsw_ctrl
`default_nettype none

// Texture sampler with wrap-around addressing over a texel memory of
// MAX_WIDTH x MAX_HEIGHT RGBA8888 words. A write transaction on req (op 0)
// stores one texel in the cycle it is accepted and gives no result; the block
// is ready again the next cycle. A sample transaction (op 1) scales the Q2.16
// coordinates by the configured size, wraps the indices, reads the memory and
// returns one RGBA transaction on rsp. All products and blends run through one
// shared multiply-accumulate unit, two products per group: coordinate scaling
// takes one group per axis, wrap reduction (at Q2.16) does one subtract per axis
// per cycle until both indices are in range and then latches the indices, the
// memory read fetches one texel (nearest) or four texels through one read port
// (bilinear), the bilinear blend takes three groups per channel, and the result
// is then handed to the output register once that register is free. A sample
// in the unused mode skips these steps and returns zero. req is not ready
// while a sample is in progress, but a finished result may wait in the output
// register while the next transaction is taken. Registers are to be written on
// cfg only while the block is idle; the block itself does not enforce this, and
// cfg is always ready.
// Texels must be written before they are sampled; the memory has no reset.

module texture_sampler_wrap_bilinear import tsw_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    tsw_cfg_if.sink    cfg,
    tsw_req_if.sink    req,
    tsw_rsp_if.source  rsp
);

    // register file
    cfg_t cfg_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tex_width   <= RST_TEX_WIDTH;
            cfg_reg.tex_height  <= RST_TEX_HEIGHT;
            cfg_reg.filter_mode <= FILT_NEAREST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            // an index past the list is dropped
            unique case (cfg.index)
                CFG_TEX_WIDTH:   cfg_reg.tex_width   <= cfg.data[SIZE_W-1:0];
                CFG_TEX_HEIGHT:  cfg_reg.tex_height  <= cfg.data[SIZE_W-1:0];
                CFG_FILTER_MODE: cfg_reg.filter_mode <= cfg.data[MODE_W-1:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // sequencer, shared mac and texel memory
    tsw_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .req   (req),
        .rsp   (rsp)
    );

`ifndef SYNTHESIS
    // a sample transaction holds off the next request
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.op == OP_SAMPLE) |=> !req.ready)
        else $error("request taken while a sample is in progress");

    // a texel write never stalls the request side
    a_write_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.op == OP_WRITE) |=> req.ready)
        else $error("texel write left the sampler busy");

    // a new result appears only as the sequencer returns to idle
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> req.ready)
        else $error("result issued while the sequencer is busy");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/tb_texture_sampler_wrap_bilinear.sv
// tb_texture_sampler_wrap_bilinear: self-checking bench for the wrap-around texture sampler
// depends on tsw_pkg, the tsw_if channel interfaces and texture_sampler_wrap_bilinear;
// every sample is predicted in the bench and checked field by field against the rsp channel

module tb_texture_sampler_wrap_bilinear;
    timeunit 1ns;
    timeprecision 1ps;

    import tsw_pkg::*;

    // fixed-point helpers at the default fraction width
    localparam int              FRAC       = DEF_FRAC_BITS;
    localparam longint unsigned ONE_FX     = 64'd1 << FRAC;
    localparam longint unsigned HALF_FX    = ONE_FX >> 1;
    localparam longint unsigned QUARTER_FX = ONE_FX >> 2;

    localparam int STORE_W     = DEF_MAX_WIDTH;
    localparam int STORE_H     = DEF_MAX_HEIGHT;
    localparam int STORE_DEPTH = STORE_W * STORE_H;

    // mode code the package enum leaves out: result is all zero
    localparam logic [MODE_W-1:0] FILT_UNUSED = 2'd3;

    // dither offsets in quarter texels, indexed by {screen_y_odd, screen_x_odd}
    localparam logic [1:0] DITHER_DU [4] = '{2'd1, 2'd2, 2'd3, 2'd0};
    localparam logic [1:0] DITHER_DV [4] = '{2'd0, 2'd3, 2'd2, 2'd1};

    // run shape
    localparam int NUM_PHASES    = 10;
    localparam int PHASE_ITEMS   = 105;
    localparam int SETTLE_CYCLES = 80;
    localparam int STALL_LIMIT   = 2000;

    // register settings per phase, extremes and out-of-range sizes among them
    localparam logic [SIZE_W-1:0] PH_W [NUM_PHASES] =
        '{7'd64, 7'd1, 7'd0, 7'd37, 7'd64, 7'd127, 7'd3, 7'd64, 7'd13, 7'd64};
    localparam logic [SIZE_W-1:0] PH_H [NUM_PHASES] =
        '{7'd64, 7'd1, 7'd127, 7'd5, 7'd64, 7'd0, 7'd64, 7'd1, 7'd42, 7'd64};
    localparam logic [MODE_W-1:0] PH_MODE [NUM_PHASES] =
        '{FILT_NEAREST, FILT_DITHER, FILT_BILINEAR, FILT_BILINEAR, FILT_BILINEAR,
          FILT_DITHER, FILT_NEAREST, FILT_UNUSED, FILT_BILINEAR, FILT_DITHER};

    typedef struct packed {
        op_t                op;
        logic [POS_W-1:0]   write_x;
        logic [POS_W-1:0]   write_y;
        logic [TEXEL_W-1:0] write_value;
        logic [COORD_W-1:0] coord_u;
        logic [COORD_W-1:0] coord_v;
        logic               screen_x_odd;
        logic               screen_y_odd;
    } tex_item_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } rgba_t;

    logic clk = 1'b0;
    logic rst_n;

    tsw_cfg_if cfg_ch ();
    tsw_req_if req_ch ();
    tsw_rsp_if rsp_ch ();

    texture_sampler_wrap_bilinear DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // texel memory image as seen by accepted write transactions
    logic [TEXEL_W-1:0] texel_mem [STORE_DEPTH];
    // texels that the stimulus has already scheduled a write for
    bit                 tex_filled [STORE_DEPTH];

    // register values in force at the block (updated on cfg transactions)
    logic [SIZE_W-1:0] live_w;
    logic [SIZE_W-1:0] live_h;
    logic [MODE_W-1:0] live_mode;
    // register values the stimulus is being planned against
    logic [SIZE_W-1:0] plan_w;
    logic [SIZE_W-1:0] plan_h;
    logic [MODE_W-1:0] plan_mode;

    tex_item_t req_backlog [$];   // items waiting for the driver
    rgba_t     rgba_due [$];      // predicted colors, oldest first

    tex_item_t next_item;
    tex_item_t seen_item;
    rgba_t     got_rgba;
    rgba_t     want_rgba;

    bit req_took;
    int send_idle_pct;
    int recv_idle_pct;
    int mismatches;
    int phase_items;
    int quiet_cycles;

    task automatic note_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_chan(input string name, input logic [CHAN_W-1:0] seen,
                              input logic [CHAN_W-1:0] exp_v);
        if (seen !== exp_v)
            note_mismatch($sformatf("%s got %02h expected %02h", name, seen, exp_v));
    endtask

    // a size register of 0 acts as 1, anything past the memory acts as the maximum
    function automatic int unsigned eff_dim(input logic [SIZE_W-1:0] reg_val,
                                            input int unsigned max_dim);
        if (reg_val == 0)
            return 1;
        if (reg_val > max_dim)
            return max_dim;
        return 32'(reg_val);
    endfunction

    // texel coordinates a sample touches, plus the bilinear fractions
    function automatic void find_taps(input tex_item_t it,
                                      input logic [SIZE_W-1:0] w_reg,
                                      input logic [SIZE_W-1:0] h_reg,
                                      input logic [MODE_W-1:0] mode,
                                      output int unsigned x_lo, output int unsigned x_hi,
                                      output int unsigned y_lo, output int unsigned y_hi,
                                      output longint unsigned fu, output longint unsigned fv);
        int unsigned     w;
        int unsigned     h;
        longint unsigned pu;
        longint unsigned pv;
        logic [1:0]      parity;
        w      = eff_dim(w_reg, STORE_W);
        h      = eff_dim(h_reg, STORE_H);
        pu     = longint'(it.coord_u) * w;
        pv     = longint'(it.coord_v) * h;
        parity = {it.screen_y_odd, it.screen_x_odd};
        fu     = 0;
        fv     = 0;
        if (mode == FILT_BILINEAR)
        begin
            // floor and ceil indices, ceil equals floor on an exact texel
            fu   = pu & (ONE_FX - 1);
            fv   = pv & (ONE_FX - 1);
            x_lo = 32'((pu >> FRAC) % w);
            x_hi = 32'(((pu >> FRAC) + (fu != 0)) % w);
            y_lo = 32'((pv >> FRAC) % h);
            y_hi = 32'(((pv >> FRAC) + (fv != 0)) % h);
        end
        else
        begin
            if (mode == FILT_DITHER)
            begin
                pu += DITHER_DU[parity] * QUARTER_FX;
                pv += DITHER_DV[parity] * QUARTER_FX;
            end
            // round half up, then wrap
            x_lo = 32'(((pu + HALF_FX) >> FRAC) % w);
            y_lo = 32'(((pv + HALF_FX) >> FRAC) % h);
            x_hi = x_lo;
            y_hi = y_lo;
        end
    endfunction

    // expected color of one sample under the registers in force
    function automatic rgba_t filter_texels(input tex_item_t it);
        int unsigned       xl, xh, yl, yh;
        longint unsigned   fu, fv;
        longint unsigned   wt [4];
        logic [TEXEL_W-1:0] tap [4];
        longint unsigned   acc;
        logic [CHAN_W-1:0] chan [4];
        int                c, k;
        if (live_mode == FILT_UNUSED)
            return '0;
        find_taps(it, live_w, live_h, live_mode, xl, xh, yl, yh, fu, fv);
        tap[0] = texel_mem[yl * STORE_W + xl];
        tap[1] = texel_mem[yl * STORE_W + xh];
        tap[2] = texel_mem[yh * STORE_W + xl];
        tap[3] = texel_mem[yh * STORE_W + xh];
        if (live_mode != FILT_BILINEAR)
            return rgba_t'(tap[0]);
        wt[0] = (ONE_FX - fu) * (ONE_FX - fv);
        wt[1] = fu * (ONE_FX - fv);
        wt[2] = (ONE_FX - fu) * fv;
        wt[3] = fu * fv;
        for (c = 0; c < 4; c++)
        begin
            acc = 0;
            for (k = 0; k < 4; k++)
                acc += longint'((tap[k] >> (24 - 8 * c)) & 32'hFF) * wt[k];
            acc     = (acc + (64'd1 << (2 * FRAC - 1))) >> (2 * FRAC);
            chan[c] = (acc > 255) ? 8'hFF : acc[7:0];
        end
        return {chan[0], chan[1], chan[2], chan[3]};
    endfunction

    // ------------------------------------------------------------------
    // stimulus construction
    // ------------------------------------------------------------------

    // every field but op random, so the ignored ones toggle too
    function automatic tex_item_t random_item();
        tex_item_t it;
        it.op           = OP_WRITE;
        it.write_x      = POS_W'($urandom);
        it.write_y      = POS_W'($urandom);
        it.write_value  = $urandom;
        it.coord_u      = COORD_W'($urandom);
        it.coord_v      = COORD_W'($urandom);
        it.screen_x_odd = 1'($urandom_range(1));
        it.screen_y_odd = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic logic [TEXEL_W-1:0] rand_texel();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // coordinate whose scaled fraction is exactly one half texel
    function automatic logic [COORD_W-1:0] half_coord(input int unsigned dim);
        int unsigned shift;
        shift = 0;
        while (dim % 2 == 0)
        begin
            dim = dim / 2;
            shift++;
        end
        return COORD_W'(32'h8000 >> shift);
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord(input int unsigned dim);
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return {2'($urandom), 16'h0};                    // on a texel center
            3:       return half_coord(dim) + {2'($urandom), 16'h0};  // rounding tie
            default: return COORD_W'($urandom);
        endcase
    endfunction

    task automatic push_item(input tex_item_t it);
        req_backlog.push_back(it);
        phase_items++;
    endtask

    task automatic queue_write(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                               input logic [TEXEL_W-1:0] val);
        tex_item_t it;
        it             = random_item();
        it.op          = OP_WRITE;
        it.write_x     = x;
        it.write_y     = y;
        it.write_value = val;
        tex_filled[y * STORE_W + x] = 1'b1;
        push_item(it);
    endtask

    task automatic ensure_written(input int unsigned x, input int unsigned y);
        if (!tex_filled[y * STORE_W + x])
            queue_write(POS_W'(x), POS_W'(y), rand_texel());
    endtask

    // a sample, preceded by writes of any texel it would read that is still blank
    task automatic queue_sample(input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v,
                                input logic sx, input logic sy);
        tex_item_t       it;
        int unsigned     xl, xh, yl, yh;
        longint unsigned fu, fv;
        it              = random_item();
        it.op           = OP_SAMPLE;
        it.coord_u      = u;
        it.coord_v      = v;
        it.screen_x_odd = sx;
        it.screen_y_odd = sy;
        if (plan_mode != FILT_UNUSED)
        begin
            find_taps(it, plan_w, plan_h, plan_mode, xl, xh, yl, yh, fu, fv);
            ensure_written(xl, yl);
            ensure_written(xh, yl);
            ensure_written(xl, yh);
            ensure_written(xh, yh);
        end
        push_item(it);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // sender holds off until the block has returned everything it owes
    task automatic wait_drained();
        while (req_backlog.size() != 0 || req_ch.valid || rgba_due.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // driver: presents backlog items on req, throttles rsp.ready
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            // a new item goes out only once the current one has been taken
            if (!req_ch.valid || req_took)
            begin
                if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_item = req_backlog.pop_front();
                    req_ch.op           <= next_item.op;
                    req_ch.write_x      <= next_item.write_x;
                    req_ch.write_y      <= next_item.write_y;
                    req_ch.write_value  <= next_item.write_value;
                    req_ch.coord_u      <= next_item.coord_u;
                    req_ch.coord_v      <= next_item.coord_v;
                    req_ch.screen_x_odd <= next_item.screen_x_odd;
                    req_ch.screen_y_odd <= next_item.screen_y_odd;
                    req_ch.valid        <= 1'b1;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // monitor: tracks registers and texels, predicts and checks results
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // register write transaction
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    CFG_TEX_WIDTH:   live_w    = cfg_ch.data;
                    CFG_TEX_HEIGHT:  live_h    = cfg_ch.data;
                    CFG_FILTER_MODE: live_mode = cfg_ch.data[MODE_W-1:0];
                    default:         ;
                endcase
            end
            // request transaction: a write updates the image, a sample owes a color
            if (req_ch.valid && req_ch.ready)
            begin
                seen_item.op           = op_t'(req_ch.op);
                seen_item.write_x      = req_ch.write_x;
                seen_item.write_y      = req_ch.write_y;
                seen_item.write_value  = req_ch.write_value;
                seen_item.coord_u      = req_ch.coord_u;
                seen_item.coord_v      = req_ch.coord_v;
                seen_item.screen_x_odd = req_ch.screen_x_odd;
                seen_item.screen_y_odd = req_ch.screen_y_odd;
                if (seen_item.op == OP_WRITE)
                    texel_mem[seen_item.write_y * STORE_W + seen_item.write_x] =
                        seen_item.write_value;
                else
                    rgba_due.push_back(filter_texels(seen_item));
            end
            // result transaction against the oldest prediction
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got_rgba = {rsp_ch.red, rsp_ch.green, rsp_ch.blue, rsp_ch.alpha};
                if (rgba_due.size() == 0)
                begin
                    note_mismatch($sformatf("result %08h with no sample outstanding",
                                            got_rgba));
                end
                else
                begin
                    want_rgba = rgba_due.pop_front();
                    check_chan("red", got_rgba.red, want_rgba.red);
                    check_chan("green", got_rgba.green, want_rgba.green);
                    check_chan("blue", got_rgba.blue, want_rgba.blue);
                    check_chan("alpha", got_rgba.alpha, want_rgba.alpha);
                end
            end
        end
        req_took = rst_n && req_ch.valid && req_ch.ready;
    end

    // watchdog: ends the run when no channel moves a transaction for too long
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("FAIL texture_sampler_wrap_bilinear");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence: reset, then one register setting per phase
    // ------------------------------------------------------------------
    initial
    begin
        int  ph;
        bit  paused;
        int  dim_u;
        int  dim_v;

        // every input known from time zero
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.op           = OP_WRITE;
        req_ch.write_x      = '0;
        req_ch.write_y      = '0;
        req_ch.write_value  = '0;
        req_ch.coord_u      = '0;
        req_ch.coord_v      = '0;
        req_ch.screen_x_odd = 1'b0;
        req_ch.screen_y_odd = 1'b0;
        rsp_ch.ready        = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = CFG_TEX_WIDTH;
        cfg_ch.data         = '0;
        req_took            = 1'b0;
        mismatches          = 0;
        quiet_cycles        = 0;
        send_idle_pct       = 0;
        recv_idle_pct       = 0;
        live_w              = RST_TEX_WIDTH;
        live_h              = RST_TEX_HEIGHT;
        live_mode           = FILT_NEAREST;
        plan_w              = RST_TEX_WIDTH;
        plan_h              = RST_TEX_HEIGHT;
        plan_mode           = FILT_NEAREST;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            // registers change only with the block idle
            if (ph > 0)
            begin
                wait_drained();
                repeat (SETTLE_CYCLES) @(posedge clk);
            end

            // idle pattern: slow receiver, then slow sender, then full rate
            if (ph < 4)
            begin
                send_idle_pct = 6;
                recv_idle_pct = 88;
            end
            else if (ph < 7)
            begin
                send_idle_pct = 88;
                recv_idle_pct = 6;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            // spare high bits of the mode write are don't-care
            write_reg(CFG_TEX_WIDTH, PH_W[ph]);
            write_reg(CFG_TEX_HEIGHT, PH_H[ph]);
            write_reg(CFG_FILTER_MODE, {5'($urandom), PH_MODE[ph]});
            plan_w    = PH_W[ph];
            plan_h    = PH_H[ph];
            plan_mode = PH_MODE[ph];
            dim_u     = eff_dim(plan_w, STORE_W);
            dim_v     = eff_dim(plan_h, STORE_H);

            phase_items = 0;
            paused      = 1'b0;

            // memory corners with extreme texel values
            if (ph == 0)
            begin
                queue_write(POS_W'(0), POS_W'(0), 32'h0000_0000);
                queue_write(POS_W'(STORE_W - 1), POS_W'(STORE_H - 1), 32'hFFFF_FFFF);
                queue_write(POS_W'(STORE_W - 1), POS_W'(0), 32'hFF00_FF00);
                queue_write(POS_W'(0), POS_W'(STORE_H - 1), 32'h00FF_00FF);
            end

            // coordinate extremes and the exact rounding tie
            queue_sample('0, '0, 1'b0, 1'b0);
            queue_sample('1, '1, 1'b1, 1'b1);
            queue_sample(half_coord(dim_u), half_coord(dim_v),
                         1'($urandom_range(1)), 1'($urandom_range(1)));

            // random mix of writes and samples
            while (phase_items < PHASE_ITEMS)
            begin
                if (!paused && phase_items >= PHASE_ITEMS / 2)
                begin
                    // sender waits for every outstanding result mid-phase
                    wait_drained();
                    paused = 1'b1;
                end
                if ($urandom_range(99) < 35)
                    queue_write(POS_W'($urandom), POS_W'($urandom), rand_texel());
                else
                    queue_sample(rand_coord(dim_u), rand_coord(dim_v),
                                 1'($urandom_range(1)), 1'($urandom_range(1)));
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (rgba_due.size() != 0)
            note_mismatch($sformatf("%0d samples never answered", rgba_due.size()));

        if (mismatches == 0)
            $display("PASS texture_sampler_wrap_bilinear");
        else
            $display("FAIL texture_sampler_wrap_bilinear");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/tsw_pkg.sv
rtl/core/tsw_if.sv
rtl/core/tsw_mac.sv
rtl/core/tsw_texmem.sv
rtl/core/tsw_ctrl.sv
rtl/core/texture_sampler_wrap_bilinear.sv
tb/sv/tb_texture_sampler_wrap_bilinear.sv
